FILE: hdl/clj_pkg.sv
// Shared types and codes for the candidate list jump-to-cursor block.
// Used by the controller, the datapath and the top level; no dependencies.
package clj_pkg;

    localparam int CODE_W   = 14;
    localparam int INDEX_W  = 14;
    localparam int CURSOR_W = 14;
    localparam int LENGTH_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_JUMP  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_MOVED   = 2'd1;
    localparam logic [1:0] STATUS_TRIED   = 2'd2;
    localparam logic [1:0] STATUS_REFUSED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DONE  = 2'd2;

    localparam logic [LENGTH_W-1:0] LIST_LENGTH_RESET = 15'd16384;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [CODE_W-1:0]  item_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] found_position;
        logic [CODE_W-1:0]  read_value;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_CUR_CHECK,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    typedef enum logic [2:0] {
        RAM_IDLE,
        RAM_RD_IDX,
        RAM_WR_IDX,
        RAM_RD_CUR,
        RAM_WR_CUR,
        RAM_RD_SCAN,
        RAM_RD_SHIFT,
        RAM_WR_SHIFT
    } ram_op_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_READ,
        RES_AT_CUR,
        RES_REFUSED,
        RES_TRIED,
        RES_MOVED
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        ram_op_t  ram_op;
        logic     scan_clear;
        logic     shift_start;
        logic     res_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       idx_in_table;
        logic       cur_in_list;
        logic       phase_done;
        logic       rdata_match;
        logic       pend_valid;
        logic       scan_more;
        logic       found_before;
        logic       shift_more;
    } dp_status_t;

endpackage

FILE: hdl/clj_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module clj_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/clj_datapath.sv
// Datapath: configuration registers, item registers, scan and shift
// pointers, code table RAM and result register. Depends on clj_pkg, clj_ram.
module clj_datapath #(
    parameter int ENTRIES = 16384
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  clj_pkg::in_item_t              item,
    input  logic                           cfg_we,
    input  logic [clj_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clj_pkg::CFG_DATA_W-1:0] cfg_data,
    input  clj_pkg::dp_cmd_t               cmd,
    output clj_pkg::dp_status_t            status,
    output logic                           done,
    output clj_pkg::result_t               result
);
    import clj_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int CW = (LW > LENGTH_W) ? LW : LENGTH_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(ENTRIES);

    logic [CURSOR_W-1:0] cursor_reg;
    logic [LENGTH_W-1:0] list_length_reg;
    logic                phase_done_reg;
    logic                pend_valid_reg;
    logic                done_reg;

    in_item_t         item_reg;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    pend_addr_reg, pend_addr_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    found_reg, found_next;
    result_t          result_reg, result_next;

    logic [CW-1:0]    len_ext, used_len, cur_ext, idx_ext, j_dec;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_addr;
    logic [CODE_W-1:0] ram_wdata, ram_rdata;

    // Clamp the list length to the table depth
    assign len_ext  = CW'(list_length_reg);
    assign used_len = (len_ext > DEPTH_C) ? DEPTH_C : len_ext;
    assign cur_ext  = CW'(cursor_reg);
    assign idx_ext  = CW'(item_reg.entry_index);
    assign j_dec    = j_reg - CW'(1);

    // Configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg      <= '0;
            list_length_reg <= LIST_LENGTH_RESET;
            phase_done_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CURSOR:      cursor_reg      <= cfg_data[CURSOR_W-1:0];
                    CFG_LIST_LENGTH: list_length_reg <= cfg_data[LENGTH_W-1:0];
                    CFG_PHASE_DONE:  phase_done_reg  <= cfg_data[0];
                    default:         ;
                endcase
            end
            pend_valid_reg <= (cmd.ram_op == RAM_RD_SCAN);
            done_reg       <= cmd.res_load;
        end
    end

    // Pointer and result next values
    always_comb
    begin
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        j_next         = j_reg;
        found_next     = found_reg;
        result_next    = result_reg;

        if (cmd.scan_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.ram_op == RAM_RD_SCAN)
        begin
            ptr_next       = ptr_reg + CW'(1);
            pend_addr_next = ptr_reg;
        end

        if (cmd.shift_start)
        begin
            j_next     = pend_addr_reg;
            found_next = pend_addr_reg;
        end
        else if (cmd.ram_op == RAM_WR_SHIFT)
        begin
            j_next = j_dec;
        end

        if (cmd.res_load)
        begin
            result_next = '0;
            unique case (cmd.res_sel)
                RES_ZERO:    ;
                RES_READ:    result_next.read_value = ram_rdata;
                RES_AT_CUR:  result_next.found_position = cursor_reg;
                RES_REFUSED: result_next.status = STATUS_REFUSED;
                RES_TRIED:
                begin
                    result_next.status         = STATUS_TRIED;
                    result_next.found_position = pend_addr_reg[INDEX_W-1:0];
                end
                RES_MOVED:
                begin
                    result_next.status         = STATUS_MOVED;
                    result_next.found_position = found_reg[INDEX_W-1:0];
                end
                default:     ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        j_reg         <= j_next;
        found_reg     <= found_next;
        result_reg    <= result_next;
    end

    // RAM port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = '0;
        ram_wdata = item_reg.item_value;
        unique case (cmd.ram_op)
            RAM_IDLE:     ;
            RAM_RD_IDX:
            begin
                ram_re   = 1'b1;
                ram_addr = idx_ext[AW-1:0];
            end
            RAM_WR_IDX:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_ext[AW-1:0];
            end
            RAM_RD_CUR:
            begin
                ram_re   = 1'b1;
                ram_addr = cur_ext[AW-1:0];
            end
            RAM_WR_CUR:
            begin
                ram_we   = 1'b1;
                ram_addr = cur_ext[AW-1:0];
            end
            RAM_RD_SCAN:
            begin
                ram_re   = 1'b1;
                ram_addr = ptr_reg[AW-1:0];
            end
            RAM_RD_SHIFT:
            begin
                ram_re   = 1'b1;
                ram_addr = j_dec[AW-1:0];
            end
            RAM_WR_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_addr  = j_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            default:      ;
        endcase
    end

    clj_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ENTRIES)
    ) u_code_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign status.req_type     = item_reg.req_type;
    assign status.idx_in_table = (idx_ext < DEPTH_C);
    assign status.cur_in_list  = (cur_ext < used_len);
    assign status.phase_done   = phase_done_reg;
    assign status.rdata_match  = (ram_rdata == item_reg.item_value);
    assign status.pend_valid   = pend_valid_reg;
    assign status.scan_more    = (ptr_reg < used_len);
    assign status.found_before = (pend_addr_reg < cur_ext);
    assign status.shift_more   = (j_reg > cur_ext);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/clj_ctrl.sv
// Controller state machine: decodes the request and sequences the cursor
// check, the table scan and the shift. Depends on clj_pkg.
module clj_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  clj_pkg::dp_status_t status,
    output clj_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import clj_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{load_item: 1'b0, ram_op: RAM_IDLE, scan_clear: 1'b0,
                       shift_start: 1'b0, res_load: 1'b0, res_sel: RES_ZERO};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.req_type)
                    REQ_WRITE:
                    begin
                        if (status.idx_in_table)
                        begin
                            cmd.ram_op = RAM_WR_IDX;
                        end
                        cmd.res_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    REQ_READ:
                    begin
                        if (status.idx_in_table)
                        begin
                            cmd.ram_op = RAM_RD_IDX;
                            state_next = ST_RD_WAIT;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    REQ_JUMP:
                    begin
                        if (status.cur_in_list)
                        begin
                            cmd.ram_op = RAM_RD_CUR;
                            state_next = ST_CUR_CHECK;
                        end
                        else if (status.phase_done)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_REFUSED;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            cmd.scan_clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_READ;
                state_next   = ST_IDLE;
            end
            ST_CUR_CHECK:
            begin
                if (status.rdata_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_AT_CUR;
                    state_next   = ST_IDLE;
                end
                else if (status.phase_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_REFUSED;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.pend_valid && status.rdata_match)
                begin
                    if (status.found_before)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_TRIED;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = ST_SHIFT_RD;
                    end
                end
                else if (status.scan_more)
                begin
                    cmd.ram_op = RAM_RD_SCAN;
                end
                else
                begin
                    // not found: nothing changes
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SHIFT_RD:
            begin
                if (status.shift_more)
                begin
                    cmd.ram_op = RAM_RD_SHIFT;
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    cmd.ram_op   = RAM_WR_CUR;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_MOVED;
                    state_next   = ST_IDLE;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.ram_op = RAM_WR_SHIFT;
                state_next = ST_SHIFT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: hdl/candidate_list_jump_to_cursor.sv
// Top level of the candidate list jump-to-cursor block.
// Instantiates clj_ctrl and clj_datapath; depends on clj_pkg.
//
//   channel   signals                              transaction
//   --------  -----------------------------------  ------------------------
//   request   start, busy, item                    start && !busy
//   result    done, result                         done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//             cfg_data
//
// A write, an unused type and an out-of-table read end at decode; a read
// waits for its RAM data. A jump decodes, checks the cursor entry when the
// cursor lies inside the list, then scans the L used entries through the
// single RAM port (one read issued per cycle, the last compare in the cycle
// after), then shifts the entries between the cursor and the hit at i, each
// move being a read then a write on that port.
// The result appears in the cycle after the request finishes, while busy is
// already low, so the next request may start in that same cycle.
// Reset clears the controller and the configuration registers (the list
// length resets to 16384); the code table holds no reset and must be written before it is read.
// The receiver cannot stall: each result is valid for exactly one cycle.
module candidate_list_jump_to_cursor #(
    parameter int ENTRIES = 16384
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  clj_pkg::in_item_t              item,
    output logic                           done,
    output clj_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [clj_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clj_pkg::CFG_DATA_W-1:0] cfg_data
);
    import clj_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_status;
    logic       cfg_we;

    // Take configuration only between requests
    assign cfg_ready = ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    // Sequence each request: decode, cursor check, scan, shift
    clj_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the table, registers and result; act on each command
    clj_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (dp_status),
        .done      (done),
        .result    (result)
    );

    // An accepted request always leaves idle on the next edge
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // A result is shown only after work and while idle
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished request");

    // Only reads carry a value, and reads report no status
    a_value_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STATUS_NONE)) |-> (result.read_value == '0))
        else $error("jump result carries a read value");

    // A refused jump reports no position
    a_refused_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STATUS_REFUSED)) |-> (result.found_position == '0))
        else $error("refused jump reports a position");

endmodule
